// ===== rtl/packet_datagram_reassembly_core_defines.svh =====
// Assertion macros shared by the reassembly core.
`ifndef PACKET_DATAGRAM_REASSEMBLY_CORE_DEFINES_SVH
`define PACKET_DATAGRAM_REASSEMBLY_CORE_DEFINES_SVH

// Check that b holds in the same cycle as a.
`define PRDR_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("reassembly core: same-cycle check failed");

// Check that b holds in the cycle after a.
`define PRDR_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("reassembly core: next-cycle check failed");

`endif

// ===== rtl/prdr_pkg.sv =====
// Package: types, codes and constants of the datagram reassembly core.
`default_nettype none
package prdr_pkg;

    localparam int unsigned MAX_DATAGRAM  = 65536;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned PAYLOAD_RESET = 32;
    localparam int unsigned ADDR_W        = 3;
    localparam int unsigned DATA_W        = 32;

    localparam logic REG_PAYLOAD_SIZE = 1'b0;
    localparam logic REG_ACK_ENABLED  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_CRC_BAD     = 3'd1,
        ST_DUMMY       = 3'd2,
        ST_NO_FIRST    = 3'd3,
        ST_RESTARTED   = 3'd4,
        ST_STRAY       = 3'd5,
        ST_OUT_OF_SYNC = 3'd6,
        ST_OVERFLOW    = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        ACT_DISCARD        = 2'd0,
        ACT_APPEND         = 2'd1,
        ACT_APPEND_DELIVER = 2'd2,
        ACT_DELIVER_ALONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_DETACH  = 2'd0,
        KIND_CRC_BAD = 2'd1,
        KIND_DUMMY   = 2'd2,
        KIND_PACKET  = 2'd3
    } kind_t;

    typedef struct packed {
        logic       mode;
        logic       hdr_first;
        logic       hdr_valid;
        logic       hdr_network;
        logic [5:0] hdr_more;
        logic       crc_good;
    } in_item_t;

    typedef struct packed {
        logic        send_ack;
        logic [2:0]  status;
        logic [1:0]  action;
        logic [15:0] write_offset;
        logic [16:0] deliver_length;
        logic        to_link_layer;
        logic        stay_awake;
    } out_item_t;

    // Classified request as it sits in the queue.
    typedef struct packed {
        kind_t      kind;
        logic       first;
        logic       link;
        logic [5:0] more;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [16:0] payload_size;
        logic        ack_enabled;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/prdr_stream_if.sv =====
// Valid/ready stream interfaces for request and result channels.
`default_nettype none
interface prdr_in_if;
    logic               valid;
    logic               ready;
    prdr_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface prdr_out_if;
    logic                valid;
    logic                ready;
    prdr_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/prdr_queue.sv =====
// Small register queue between the classifier and the execution stage.
`default_nettype none
module prdr_queue #(
    parameter int unsigned DEPTH = prdr_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire prdr_pkg::cmd_t    push_data,
    input  wire logic              pop,
    output prdr_pkg::cmd_t         pop_data,
    output prdr_pkg::q_status_t    q_stat
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    prdr_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(DEPTH - 1))
            res = '0;
        else
            res = ptr + PTR_W'(1);
        return res;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
endmodule
`default_nettype wire

// ===== rtl/prdr_front.sv =====
// Front end: accept requests and classify them into queue commands.
`default_nettype none
module prdr_front (
    prdr_in_if.sink                     pkt,
    input  wire prdr_pkg::q_status_t    q_stat,
    output logic                        push,
    output prdr_pkg::cmd_t              push_data
);
    assign pkt.ready = !q_stat.full;
    assign push      = pkt.valid && !q_stat.full;

    always_comb
    begin
        push_data.first = pkt.data.hdr_first;
        push_data.link  = !pkt.data.hdr_network;
        push_data.more  = pkt.data.hdr_more;
        // Detach wins over everything, then CRC, then dummy.
        priority if (pkt.data.mode)
            push_data.kind = prdr_pkg::KIND_DETACH;
        else if (!pkt.data.crc_good)
            push_data.kind = prdr_pkg::KIND_CRC_BAD;
        else if (!pkt.data.hdr_valid)
            push_data.kind = prdr_pkg::KIND_DUMMY;
        else
            push_data.kind = prdr_pkg::KIND_PACKET;
    end
endmodule
`default_nettype wire

// ===== rtl/prdr_back.sv =====
// Back end: reassembly state, decisions and the result register.
`default_nettype none
module prdr_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire prdr_pkg::cfg_t         cfg,
    input  wire prdr_pkg::q_status_t    q_stat,
    input  wire prdr_pkg::cmd_t         pop_data,
    output logic                        pop,
    prdr_out_if.source                  res
);
    logic                first_bit_seen_reg, first_bit_seen_next;
    logic [7:0]          packets_left_reg, packets_left_next;
    logic [16:0]         fill_index_reg, fill_index_next;
    logic                out_valid_reg, out_valid_next;
    prdr_pkg::out_item_t out_data_reg, out_data_next;

    logic                fbs;
    logic [16:0]         fill_a;
    logic [7:0]          left_a;
    logic [7:0]          left_dec;
    logic [7:0]          more_w;
    logic [17:0]         sum;
    logic [16:0]         sum_sat;
    logic                done;
    prdr_pkg::status_t   status;
    prdr_pkg::action_t   action;

    // Advance when the result slot is free or is being drained.
    assign pop = !q_stat.empty && (!out_valid_reg || res.ready);

    always_comb
    begin
        first_bit_seen_next = first_bit_seen_reg;
        packets_left_next   = packets_left_reg;
        fill_index_next     = fill_index_reg;
        out_valid_next      = out_valid_reg && !res.ready;
        out_data_next       = out_data_reg;

        fbs      = first_bit_seen_reg | (pop_data.link & pop_data.first);
        more_w   = {2'b00, pop_data.more};
        left_dec = packets_left_reg - 8'd1;
        fill_a   = fill_index_reg;
        left_a   = packets_left_reg;
        sum      = '0;
        sum_sat  = '0;
        done     = 1'b0;
        status   = prdr_pkg::ST_OK;
        action   = prdr_pkg::ACT_DISCARD;

        out_data_next = '0;

        unique case (pop_data.kind)
            prdr_pkg::KIND_DETACH:
            begin
                first_bit_seen_next = 1'b0;
                left_a              = '0;
                fill_index_next     = '0;
            end
            prdr_pkg::KIND_CRC_BAD:
            begin
                status = prdr_pkg::ST_CRC_BAD;
                if (!cfg.ack_enabled)
                begin
                    left_a          = '0;
                    fill_index_next = '0;
                end
            end
            prdr_pkg::KIND_DUMMY:
            begin
                out_data_next.send_ack = 1'b1;
                status                 = prdr_pkg::ST_DUMMY;
            end
            default:
            begin
                out_data_next.send_ack = 1'b1;
                first_bit_seen_next    = fbs;
                if (cfg.payload_size == 17'(prdr_pkg::MAX_DATAGRAM))
                begin
                    if (!fbs || pop_data.first)
                    begin
                        action                       = prdr_pkg::ACT_DELIVER_ALONE;
                        out_data_next.deliver_length = cfg.payload_size;
                        out_data_next.to_link_layer  = pop_data.link;
                    end
                    else
                        status = prdr_pkg::ST_NO_FIRST;
                end
                else
                begin
                    if (fbs && pop_data.first)
                    begin
                        if (fill_index_reg != '0)
                        begin
                            status = prdr_pkg::ST_RESTARTED;
                            fill_a = '0;
                        end
                        left_a = more_w;
                    end
                    else if (fbs)
                    begin
                        if (fill_index_reg == '0)
                        begin
                            status = prdr_pkg::ST_STRAY;
                            done   = 1'b1;
                        end
                        else if (more_w != left_dec)
                        begin
                            status = prdr_pkg::ST_OUT_OF_SYNC;
                            fill_a = '0;
                            left_a = '0;
                            done   = 1'b1;
                        end
                        else
                            left_a = left_dec;
                    end

                    fill_index_next = fill_a;
                    if (!done)
                    begin
                        if (fill_a >= 17'(prdr_pkg::MAX_DATAGRAM))
                        begin
                            status          = prdr_pkg::ST_OVERFLOW;
                            fill_index_next = '0;
                        end
                        else
                        begin
                            // Saturate the fill index at its 17-bit limit.
                            sum     = {1'b0, fill_a} + {1'b0, cfg.payload_size};
                            sum_sat = sum[17] ? '1 : sum[16:0];
                            out_data_next.write_offset = fill_a[15:0];
                            if (pop_data.more != '0)
                            begin
                                action          = prdr_pkg::ACT_APPEND;
                                fill_index_next = sum_sat;
                            end
                            else
                            begin
                                action                       = prdr_pkg::ACT_APPEND_DELIVER;
                                fill_index_next              = '0;
                                out_data_next.deliver_length = sum_sat;
                                out_data_next.to_link_layer  = pop_data.link;
                            end
                        end
                    end
                end
            end
        endcase

        packets_left_next        = left_a;
        out_data_next.status     = status;
        out_data_next.action     = action;
        out_data_next.stay_awake = (left_a > 8'd1);

        if (!pop)
        begin
            first_bit_seen_next = first_bit_seen_reg;
            packets_left_next   = packets_left_reg;
            fill_index_next     = fill_index_reg;
            out_data_next       = out_data_reg;
        end
        else
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_bit_seen_reg <= 1'b0;
            packets_left_reg   <= '0;
            fill_index_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            first_bit_seen_reg <= first_bit_seen_next;
            packets_left_reg   <= packets_left_next;
            fill_index_reg     <= fill_index_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;
endmodule
`default_nettype wire

// ===== rtl/packet_datagram_reassembly_core.sv =====
// Top level of the packet datagram reassembly core with its register port.
`default_nettype none
`include "packet_datagram_reassembly_core_defines.svh"
// The core takes one request per cycle while its queue has room: the header
// of a received packet (first bit, real/dummy bit, link/network type, count
// of packets still to come) together with its CRC result, or a detach
// request that clears all reassembly state. For every request it returns
// exactly one result: whether to acknowledge, a status code, and an action
// (discard, append the payload at write_offset, append and deliver the
// finished datagram, or deliver the packet on its own), with the delivered
// length, the handler it goes to and a stay-awake hint. Throughput is one
// request per cycle while results are taken. A request is written into the
// command queue when it is accepted; the execution stage pops it, updates
// the reassembly state and registers the result, which it offers until it
// is taken. A result that is not taken holds the execution stage, and the
// two-entry queue takes up to two more requests before the input stalls;
// once the result moves again, the input stays stalled until the full queue
// has freed an entry. The two registers (payload_size at byte 0,
// ack_enabled at byte 4) are written through the APB-style port and must
// be changed only while no request is in flight.
module packet_datagram_reassembly_core #(
    parameter int unsigned QUEUE_DEPTH = prdr_pkg::QUEUE_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    prdr_in_if.sink                             pkt,
    prdr_out_if.source                          res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [prdr_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [prdr_pkg::DATA_W-1:0]    pwdata,
    output logic      [prdr_pkg::DATA_W-1:0]    prdata,
    output logic                                pready
);
    logic [16:0]          payload_size_q_reg, payload_size_next;
    logic                 ack_enabled_reg, ack_enabled_next;
    logic                 cfg_write;
    prdr_pkg::cfg_t       cfg;
    prdr_pkg::q_status_t  q_stat;
    prdr_pkg::cmd_t       push_data;
    prdr_pkg::cmd_t       pop_data;
    logic                 push;
    logic                 pop;

    // Register port: zero wait states, register index from address bit 2.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        payload_size_next = payload_size_q_reg;
        ack_enabled_next  = ack_enabled_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                prdr_pkg::REG_PAYLOAD_SIZE: payload_size_next = pwdata[16:0];
                prdr_pkg::REG_ACK_ENABLED:  ack_enabled_next  = pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            prdr_pkg::REG_PAYLOAD_SIZE:
                prdata = {{(prdr_pkg::DATA_W - 17){1'b0}}, payload_size_q_reg};
            prdr_pkg::REG_ACK_ENABLED:
                prdata = {{(prdr_pkg::DATA_W - 1){1'b0}}, ack_enabled_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_size_q_reg <= 17'(prdr_pkg::PAYLOAD_RESET);
            ack_enabled_reg    <= 1'b0;
        end
        else
        begin
            payload_size_q_reg <= payload_size_next;
            ack_enabled_reg    <= ack_enabled_next;
        end
    end

    assign cfg.payload_size = payload_size_q_reg;
    assign cfg.ack_enabled  = ack_enabled_reg;

    // Classify incoming requests into the command queue.
    prdr_front u_front (
        .pkt       (pkt),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    prdr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // Execute commands against the reassembly state and hold the result.
    prdr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .res      (res)
    );

    // A result without acknowledge never moves payload.
    `PRDR_ASSERT_SAME(a_noack_discards, clk, rst_n,
        res.valid && !res.data.send_ack,
        res.data.action == prdr_pkg::ACT_DISCARD)
    // A discarded packet carries no offset, length or handler.
    `PRDR_ASSERT_SAME(a_discard_clean, clk, rst_n,
        res.valid && res.data.action == prdr_pkg::ACT_DISCARD,
        res.data.write_offset == '0 && res.data.deliver_length == '0
        && !res.data.to_link_layer)
    // A queue command is taken only when a command is waiting.
    `PRDR_ASSERT_SAME(a_pop_nonempty, clk, rst_n, pop, !q_stat.empty)
    // A stalled result stays valid the next cycle.
    `PRDR_ASSERT_NEXT(a_result_held, clk, rst_n,
        res.valid && !res.ready, res.valid)
endmodule
`default_nettype wire
